@@ sv/ddo_pkg.sv @@
// Shared types, constants and helper functions for the differential-drive odometry block.
`timescale 1ns / 1ps

package ddo_pkg;

   // Fraction bits of the angle and pose words.
   localparam int FRAC_BITS = 16;
   // Fraction bits of both configuration gains.
   localparam int CFG_FRAC = 16;
   // Fraction bits of the narrowed cosine and sine.
   localparam int TRIG_FRAC = 24;

   localparam int WORD_WIDTH = 32;
   localparam int HALF_RADIUS_WIDTH = 16;
   localparam int ROTATION_GAIN_WIDTH = 24;
   localparam int CSR_DATA_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HALF_RADIUS   = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROTATION_GAIN = 1'd1;

   // round(2^32 / (2 pi)): heading in radians to turns in Q0.32.
   localparam logic [35:0] INV_TWO_PI_Q32 = 36'd683565276;
   // pi in Q30.
   localparam logic [35:0] PI_Q30 = 36'd3373259426;
   // CORDIC start value, the inverse rotation gain in Q30.
   localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
   localparam int CORDIC_STEPS = 24;
   localparam int ITER_WIDTH = $clog2(CORDIC_STEPS);

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] left_angle;
      logic signed [WORD_WIDTH-1:0] right_angle_raw;
   } ddo_req_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] pos_x;
      logic signed [WORD_WIDTH-1:0] pos_y;
      logic signed [WORD_WIDTH-1:0] heading;
   } ddo_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PHASE,
      ST_RESID,
      ST_ZLOAD,
      ST_CORDIC,
      ST_MAP,
      ST_MULX,
      ST_MULY,
      ST_ACCY,
      ST_PUSH
   } ddo_state_type;

   // Arctangent of 2^-i in Q30.
   function automatic logic signed [32:0] cordic_atan(input logic [ITER_WIDTH-1:0] idx);
      logic signed [32:0] val;
      case (idx)
         5'd0:    val = 33'sd843314856;
         5'd1:    val = 33'sd497837829;
         5'd2:    val = 33'sd263043836;
         5'd3:    val = 33'sd133525158;
         5'd4:    val = 33'sd67021686;
         5'd5:    val = 33'sd33543515;
         5'd6:    val = 33'sd16775850;
         5'd7:    val = 33'sd8388437;
         5'd8:    val = 33'sd4194282;
         5'd9:    val = 33'sd2097149;
         5'd10:   val = 33'sd1048575;
         5'd11:   val = 33'sd524287;
         5'd12:   val = 33'sd262143;
         5'd13:   val = 33'sd131071;
         5'd14:   val = 33'sd65535;
         5'd15:   val = 33'sd32767;
         5'd16:   val = 33'sd16383;
         5'd17:   val = 33'sd8191;
         5'd18:   val = 33'sd4095;
         5'd19:   val = 33'sd2047;
         5'd20:   val = 33'sd1023;
         5'd21:   val = 33'sd511;
         5'd22:   val = 33'sd255;
         5'd23:   val = 33'sd127;
         default: val = 33'sd0;
      endcase
      return val;
   endfunction

   // Clamps a widened sum to the signed 32-bit range.
   function automatic logic [WORD_WIDTH-1:0] sat32(input logic signed [43:0] v);
      logic [WORD_WIDTH-1:0] res;
      if (v > 44'sd2147483647) begin
         res = 32'h7FFF_FFFF;
      end else if (v < -44'sd2147483648) begin
         res = 32'h8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

@@ sv/ddo_stream_if.sv @@
// Valid/ready stream interfaces for the odometry sample and pose words.
`timescale 1ns / 1ps

interface ddo_req_if;
   import ddo_pkg::*;

   logic        valid;
   logic        ready;
   ddo_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ddo_rsp_if;
   import ddo_pkg::*;

   logic        valid;
   logic        ready;
   ddo_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ sv/differential_drive_odometry_core.sv @@
// Differential-drive dead-reckoning odometry core with a shared multiplier and an iterative CORDIC.
`timescale 1ns / 1ps

//  Channel    Direction  Word contents                         Handshake
//  req_chan   in         left_angle, right_angle_raw (Q16.16)  valid / ready
//  rsp_chan   out        pos_x, pos_y, heading (Q16.16)        valid / ready
//  csr_*      in         half_radius, rotation_gain            write enable only
//
// A pose word is loaded into the output register in the push state, and the next sample can be
// taken in the cycle after it. The states run: phase and residual products of the shared
// 36 x 33 multiplier, CORDIC load, the 24 CORDIC iterations, quadrant map, x and y products,
// y accumulation and push. The heading step and travel products are formed under the CORDIC
// load and its first iteration. Reset is synchronous and clears gains, wheel angles and pose;
// the push stalls while the output register is full and its word is not being taken.

module differential_drive_odometry_core
   import ddo_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   ddo_req_if.sink                    req_chan,
   ddo_rsp_if.source                  rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   ddo_state_type state_ff, state_in;

   // Configuration registers.
   logic [HALF_RADIUS_WIDTH-1:0]   half_radius_ff, half_radius_in;
   logic [ROTATION_GAIN_WIDTH-1:0] rotation_gain_ff, rotation_gain_in;

   // Architectural state: last wheel readings and the pose accumulators.
   logic signed [WORD_WIDTH-1:0] last_left_ff, last_left_in;
   logic signed [WORD_WIDTH-1:0] last_right_ff, last_right_in;
   logic signed [WORD_WIDTH-1:0] acc_x_ff, acc_x_in;
   logic signed [WORD_WIDTH-1:0] acc_y_ff, acc_y_in;
   logic signed [WORD_WIDTH-1:0] acc_heading_ff, acc_heading_in;

   // Working registers of one sample.
   logic signed [34:0] wheel_sum_ff, wheel_sum_in;
   logic signed [34:0] wheel_diff_ff, wheel_diff_in;
   logic [1:0]         quad_ff, quad_in;
   logic signed [68:0] prod_ff, prod_in;
   logic signed [32:0] cx_ff, cx_in;
   logic signed [32:0] cy_ff, cy_in;
   logic signed [32:0] cz_ff, cz_in;
   logic [ITER_WIDTH-1:0] iter_ff, iter_in;
   logic signed [42:0] dth_ff, dth_in;
   logic signed [34:0] travel_ff, travel_in;
   logic signed [27:0] cos_ff, cos_in;
   logic signed [27:0] sin_ff, sin_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   ddo_rsp_type rsp_data_ff, rsp_data_in;

   // Shared multiplier operands.
   logic signed [35:0] mul_a;
   logic signed [32:0] mul_b;

   // Combinational helpers.
   logic signed [32:0] d_left;
   logic signed [32:0] d_right;
   logic [31:0]        phase;
   logic signed [68:0] round_cfg;
   logic signed [68:0] round_trig;
   logic signed [32:0] x_shift;
   logic signed [32:0] y_shift;
   logic signed [32:0] atan_val;
   logic signed [33:0] c_raw;
   logic signed [33:0] s_raw;
   logic signed [33:0] c_rnd;
   logic signed [33:0] s_rnd;
   logic signed [34:0] step_xy;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // The right wheel reads mirrored, so its delta is taken the other way round.
   assign d_left  = 33'(req_chan.data.left_angle) - 33'(last_left_ff);
   assign d_right = 33'(last_right_ff) - 33'(req_chan.data.right_angle_raw);

   // Heading in turns (Q0.32), taken modulo one turn by the bit-select.
   assign phase = prod_ff[FRAC_BITS+31:FRAC_BITS];

   // Round half up before the arithmetic right shift.
   assign round_cfg  = prod_ff + (69'sd1 <<< (CFG_FRAC - 1));
   assign round_trig = prod_ff + (69'sd1 <<< (TRIG_FRAC - 1));
   assign step_xy    = round_trig[TRIG_FRAC+34:TRIG_FRAC];

   assign x_shift  = cx_ff >>> iter_ff;
   assign y_shift  = cy_ff >>> iter_ff;
   assign atan_val = cordic_atan(iter_ff);

   // Quadrant map of the first-quadrant CORDIC result.
   always_comb begin
      case (quad_ff)
         2'd0: begin
            c_raw = 34'(cx_ff);
            s_raw = 34'(cy_ff);
         end
         2'd1: begin
            c_raw = -34'(cy_ff);
            s_raw = 34'(cx_ff);
         end
         2'd2: begin
            c_raw = -34'(cx_ff);
            s_raw = -34'(cy_ff);
         end
         default: begin
            c_raw = 34'(cy_ff);
            s_raw = -34'(cx_ff);
         end
      endcase
   end

   assign c_rnd = c_raw + 34'sd32;
   assign s_rnd = s_raw + 34'sd32;

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (state_ff)
         ST_PHASE: begin
            mul_a = INV_TWO_PI_Q32;
            mul_b = 33'(acc_heading_ff);
         end
         ST_RESID: begin
            mul_a = PI_Q30;
            mul_b = {3'b000, phase[29:0]};
         end
         ST_ZLOAD: begin
            mul_a = 36'(wheel_diff_ff);
            mul_b = {9'd0, rotation_gain_ff};
         end
         ST_CORDIC: begin
            mul_a = 36'(wheel_sum_ff);
            mul_b = {17'd0, half_radius_ff};
         end
         ST_MULX: begin
            mul_a = 36'(travel_ff);
            mul_b = 33'(cos_ff);
         end
         ST_MULY: begin
            mul_a = 36'(travel_ff);
            mul_b = 33'(sin_ff);
         end
         default: begin
            mul_a = 36'sd0;
            mul_b = 33'sd0;
         end
      endcase
   end

   assign prod_in = 69'(mul_a * mul_b);

   // Sequencer: next state and all register updates.
   always_comb begin
      state_in         = state_ff;
      half_radius_in   = half_radius_ff;
      rotation_gain_in = rotation_gain_ff;
      last_left_in     = last_left_ff;
      last_right_in    = last_right_ff;
      acc_x_in         = acc_x_ff;
      acc_y_in         = acc_y_ff;
      acc_heading_in   = acc_heading_ff;
      wheel_sum_in     = wheel_sum_ff;
      wheel_diff_in    = wheel_diff_ff;
      quad_in          = quad_ff;
      cx_in            = cx_ff;
      cy_in            = cy_ff;
      cz_in            = cz_ff;
      iter_in          = iter_ff;
      dth_in           = dth_ff;
      travel_in        = travel_ff;
      cos_in           = cos_ff;
      sin_in           = sin_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HALF_RADIUS:   half_radius_in   = csr_write_data[HALF_RADIUS_WIDTH-1:0];
            CSR_ROTATION_GAIN: rotation_gain_in = csr_write_data[ROTATION_GAIN_WIDTH-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               wheel_sum_in  = 35'(d_right) + 35'(d_left);
               wheel_diff_in = 35'(d_right) - 35'(d_left);
               last_left_in  = req_chan.data.left_angle;
               last_right_in = req_chan.data.right_angle_raw;
               state_in      = ST_PHASE;
            end
         end
         ST_PHASE: begin
            state_in = ST_RESID;
         end
         ST_RESID: begin
            quad_in  = phase[31:30];
            state_in = ST_ZLOAD;
         end
         ST_ZLOAD: begin
            // Residual angle within the quadrant, Q30 radians.
            cz_in    = {2'b00, prod_ff[61:31]};
            cx_in    = CORDIC_GAIN_Q30;
            cy_in    = 33'sd0;
            iter_in  = '0;
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            if (!cz_ff[32]) begin
               cx_in = cx_ff - y_shift;
               cy_in = cy_ff + x_shift;
               cz_in = cz_ff - atan_val;
            end else begin
               cx_in = cx_ff + y_shift;
               cy_in = cy_ff - x_shift;
               cz_in = cz_ff + atan_val;
            end
            // The heading step product arrives in the first iteration and the
            // travel product in the second.
            if (iter_ff == '0) begin
               dth_in = round_cfg[CFG_FRAC+42:CFG_FRAC];
            end
            if (iter_ff == ITER_WIDTH'(1)) begin
               travel_in = round_cfg[CFG_FRAC+34:CFG_FRAC];
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_WIDTH'(CORDIC_STEPS - 1)) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            cos_in = c_rnd[33:6];
            sin_in = s_rnd[33:6];
            // The old heading has been used, so the new one may be stored now.
            acc_heading_in = sat32(44'(acc_heading_ff) + 44'(dth_ff));
            state_in       = ST_MULX;
         end
         ST_MULX: begin
            state_in = ST_MULY;
         end
         ST_MULY: begin
            acc_x_in = sat32(44'(acc_x_ff) + 44'(step_xy));
            state_in = ST_ACCY;
         end
         ST_ACCY: begin
            acc_y_in = sat32(44'(acc_y_ff) + 44'(step_xy));
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.pos_x   = acc_x_ff;
               rsp_data_in.pos_y   = acc_y_ff;
               rsp_data_in.heading = acc_heading_ff;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_radius_ff   <= '0;
         rotation_gain_ff <= '0;
         last_left_ff     <= '0;
         last_right_ff    <= '0;
         acc_x_ff         <= '0;
         acc_y_ff         <= '0;
         acc_heading_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         half_radius_ff   <= half_radius_in;
         rotation_gain_ff <= rotation_gain_in;
         last_left_ff     <= last_left_in;
         last_right_ff    <= last_right_in;
         acc_x_ff         <= acc_x_in;
         acc_y_ff         <= acc_y_in;
         acc_heading_ff   <= acc_heading_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wheel_sum_ff  <= wheel_sum_in;
      wheel_diff_ff <= wheel_diff_in;
      quad_ff       <= quad_in;
      prod_ff       <= prod_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      cz_ff         <= cz_in;
      iter_ff       <= iter_in;
      dth_ff        <= dth_in;
      travel_ff     <= travel_in;
      cos_ff        <= cos_in;
      sin_ff        <= sin_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the differential-drive odometry core.
`timescale 1ns / 1ps

module testbench;
   import ddo_pkg::*;

   // Cycles with no accepted word on either channel before the run is abandoned. This leaves
   // a wide margin over the slowest correct word, with random idling on both channels, and over
   // the idle pause before a gain change.
   localparam int STALL_LIMIT = 3000;
   // Cycles allowed after the last pose word.
   localparam int SETTLE_CYCLES = 40;
   // Largest per-sample wheel movement in the well-formed random words: two radians.
   localparam int WHEEL_STEP = 131072;
   localparam int RANDOM_PHASES = 6;
   localparam int WORDS_PER_PHASE = 305;

   // Scaling constants of the heading-to-phase conversion and the CORDIC.
   localparam longint unsigned TURNS_PER_RADIAN = 64'd683565276;
   localparam longint unsigned PI_IN_Q30 = 64'd3373259426;
   localparam longint CORDIC_START = 64'sd652032874;

   // Tracks the robot pose exactly as the core should, holds the pose words still owed
   // by the core and compares each returned word against the oldest of them.
   class odometry_pose_tracker;
      longint half_radius;
      longint rotation_gain;
      longint last_left;
      longint last_right;
      longint acc_x;
      longint acc_y;
      longint acc_heading;
      longint atan_table[24];
      ddo_rsp_type expected_poses[$];
      int mismatches;
      int samples;
      int poses;

      function new();
         atan_table = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                        127};
      endfunction

      function void set_gain(logic [CSR_INDEX_WIDTH-1:0] index,
                             logic [CSR_DATA_WIDTH-1:0] value);
         if (index == CSR_HALF_RADIUS) begin
            half_radius = longint'(value[HALF_RADIUS_WIDTH-1:0]);
         end else if (index == CSR_ROTATION_GAIN) begin
            rotation_gain = longint'(value[ROTATION_GAIN_WIDTH-1:0]);
         end
      endfunction

      // Right shift that rounds half up.
      function longint round_shift(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function longint saturate(longint v);
         if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
         end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
         end
         return v;
      endfunction

      // Q24 cosine and sine of a Q16.16 heading, reduced to one turn first.
      function void heading_trig(longint theta, output longint cos_q24,
                                 output longint sin_q24);
         longint unsigned prod;
         logic [31:0] phase;
         longint z;
         longint cx;
         longint cy;
         longint nx;
         longint c;
         longint s;
         int i;
         prod = $unsigned(theta) * TURNS_PER_RADIAN;
         phase = prod[FRAC_BITS +: 32];
         z = longint'(({34'd0, phase[29:0]} * PI_IN_Q30) >> 31);
         cx = CORDIC_START;
         cy = 0;
         for (i = 0; i < 24; i++) begin
            if (z >= 0) begin
               nx = cx - (cy >>> i);
               cy = cy + (cx >>> i);
               z -= atan_table[i];
            end else begin
               nx = cx + (cy >>> i);
               cy = cy - (cx >>> i);
               z += atan_table[i];
            end
            cx = nx;
         end
         case (phase[31:30])
            2'd0: begin c = cx; s = cy; end
            2'd1: begin c = -cy; s = cx; end
            2'd2: begin c = -cx; s = -cy; end
            default: begin c = cy; s = -cx; end
         endcase
         cos_q24 = round_shift(c, 6);
         sin_q24 = round_shift(s, 6);
      endfunction

      // Integrates one accepted sample word and queues the pose word it must produce.
      function void integrate_sample(ddo_req_type word);
         longint left;
         longint right_raw;
         longint d_left;
         longint d_right;
         longint cos_q24;
         longint sin_q24;
         longint travel;
         longint d_heading;
         ddo_rsp_type pose;
         left = word.left_angle;
         right_raw = word.right_angle_raw;
         d_left = left - last_left;
         d_right = last_right - right_raw;
         last_left = left;
         last_right = right_raw;
         heading_trig(acc_heading, cos_q24, sin_q24);
         d_heading = round_shift((d_right - d_left) * rotation_gain, CFG_FRAC);
         travel = round_shift((d_right + d_left) * half_radius, CFG_FRAC);
         acc_x = saturate(acc_x + round_shift(travel * cos_q24, TRIG_FRAC));
         acc_y = saturate(acc_y + round_shift(travel * sin_q24, TRIG_FRAC));
         acc_heading = saturate(acc_heading + d_heading);
         pose.pos_x = acc_x[31:0];
         pose.pos_y = acc_y[31:0];
         pose.heading = acc_heading[31:0];
         expected_poses.push_back(pose);
         samples++;
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) begin
            $display("MISMATCH: %s", what);
         end
      endfunction

      function void check_field(string field, logic signed [31:0] want,
                                logic signed [31:0] got);
         if (want !== got) begin
            flag($sformatf("pose word %0d %s expected %0d, got %0d", poses, field, want, got));
         end
      endfunction

      function void check_pose(ddo_rsp_type got);
         ddo_rsp_type want;
         if (expected_poses.size() == 0) begin
            flag($sformatf("pose word %0d arrived with no sample outstanding", poses));
         end else begin
            want = expected_poses.pop_front();
            check_field("pos_x", want.pos_x, got.pos_x);
            check_field("pos_y", want.pos_y, got.pos_y);
            check_field("heading", want.heading, got.heading);
         end
         poses++;
      endfunction

      function int outstanding();
         return expected_poses.size();
      endfunction

      function void close_out();
         if (expected_poses.size() != 0) begin
            flag($sformatf("%0d pose words never arrived", expected_poses.size()));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data;

   ddo_req_if req_link();
   ddo_rsp_if rsp_link();

   odometry_pose_tracker tracker = new;

   // Wheel angles of the last accepted sample, used to build plausible continuations.
   logic [31:0] sent_left = '0;
   logic [31:0] sent_right = '0;
   // Words left in the current stretch without idling, one count per channel.
   int sender_calm = 0;
   int receiver_calm = 0;
   int gain_settings = 0;
   int idle_cycles = 0;

   differential_drive_odometry_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_link.sink),
      .rsp_chan         (rsp_link.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle cycles before the next word on one channel. Now and then a stretch of words
   // goes through without any idling, so back-to-back traffic is covered as well.
   function automatic int draw_gap(inout int calm_left);
      int gap;
      gap = 0;
      if (calm_left > 0) begin
         calm_left--;
      end else if ($urandom_range(0, 29) == 0) begin
         calm_left = $urandom_range(8, 40);
      end else begin
         gap = $urandom_range(0, 17);
      end
      return gap;
   endfunction

   // Offers one sample word and returns in the time step of its acceptance. Valid is
   // left high there: the caller either offers the next word at once or lowers it.
   task automatic send_sample(input logic [31:0] left, input logic [31:0] right);
      int gap;
      ddo_req_type word;
      gap = draw_gap(sender_calm);
      word.left_angle = left;
      word.right_angle_raw = right;
      if (gap > 0) begin
         req_link.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_link.valid <= 1'b1;
      req_link.data <= word;
      do @(posedge clock); while (!req_link.ready);
      tracker.integrate_sample(word);
      sent_left = left;
      sent_right = right;
   endtask

   // Holds the sample channel until every pose word owed has come back, then waits the
   // given number of further cycles.
   task automatic drain_poses(input int tail);
      req_link.valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // Writes both gain registers on consecutive edges; the enable stays high in between.
   task automatic program_gains(input logic [CSR_DATA_WIDTH-1:0] half_word,
                                input logic [CSR_DATA_WIDTH-1:0] rotation_word);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_HALF_RADIUS;
      csr_write_data <= half_word;
      @(posedge clock);
      csr_index <= CSR_ROTATION_GAIN;
      csr_write_data <= rotation_word;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_gain(CSR_HALF_RADIUS, half_word);
      tracker.set_gain(CSR_ROTATION_GAIN, rotation_word);
      gain_settings++;
   endtask

   function automatic logic [31:0] corner_angle();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return 32'h0000_0001;
      endcase
   endfunction

   // Pose words are taken with random stalls for the whole run and checked as they come.
   initial begin : pose_sink
      int gap;
      rsp_link.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         gap = draw_gap(receiver_calm);
         if (gap > 0) begin
            rsp_link.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_link.ready <= 1'b1;
         do @(posedge clock); while (!rsp_link.valid);
         tracker.check_pose(rsp_link.data);
      end
   end

   // Watchdog: any accepted word on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_link.valid && req_link.ready) || (rsp_link.valid && rsp_link.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("differential_drive_odometry_core verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [31:0] edge_left[8];
      logic [31:0] edge_right[8];
      logic [31:0] left;
      logic [31:0] right;
      int choice;
      int step;
      int phase;
      int n;
      int k;

      reset <= 1'b1;
      req_link.valid <= 1'b0;
      req_link.data <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_HALF_RADIUS;
      csr_write_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // With both gains still at their reset value of zero the pose must not move, however
      // far the wheels jump; the stored wheel angles are updated all the same.
      send_sample(32'h7FFF_FFFF, 32'h8000_0000);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF);
      drain_poses(SETTLE_CYCLES);

      // Largest gains. The top byte of the half radius word lies above the register and
      // must be dropped. The wheel jumps below drive x to both saturation limits and the
      // heading to both limits, after which the trigonometry sees a heading many turns long.
      program_gains(24'hFF_FFFF, 24'hFF_FFFF);
      edge_left  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000};
      edge_right = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000};
      for (k = 0; k < 8; k++) begin
         send_sample(edge_left[k], edge_right[k]);
      end
      drain_poses(SETTLE_CYCLES);

      // Plausible robot gains: drive forward, spin on the spot, then reverse. The right
      // encoder is mirrored, so forward travel makes its raw angle fall.
      program_gains(24'd3277, 24'd13107);
      for (k = 0; k < 10; k++) begin
         if (k < 4) begin
            send_sample(sent_left + 32'd65536, sent_right - 32'd65536);
         end else if (k < 7) begin
            send_sample(sent_left + 32'd32768, sent_right + 32'd32768);
         end else begin
            send_sample(sent_left - 32'd65536, sent_right + 32'd65536);
         end
      end

      // Random phases, each under its own gain setting: a heading-only and a travel-only
      // extreme first, then realistic gains and finally fully random register words.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_poses(SETTLE_CYCLES);
         case (phase)
            0: program_gains(24'd0, 24'hFF_FFFF);
            1: program_gains(24'hFF_FFFF, 24'd0);
            5: program_gains(24'($urandom), 24'($urandom));
            default: program_gains({8'($urandom), 16'($urandom_range(500, 8000))},
                                   24'($urandom_range(2000, 60000)));
         endcase
         for (n = 0; n < WORDS_PER_PHASE; n++) begin
            choice = $urandom_range(0, 99);
            if (choice < 50) begin
               // Independent wheel movements of up to two radians each.
               left = sent_left + $urandom_range(0, 2 * WHEEL_STEP) - WHEEL_STEP;
               right = sent_right + $urandom_range(0, 2 * WHEEL_STEP) - WHEEL_STEP;
            end else if (choice < 75) begin
               // Nearly straight travel with a little slip on the right wheel.
               step = $urandom_range(0, 2 * WHEEL_STEP) - WHEEL_STEP;
               left = sent_left + step;
               right = sent_right - step + $urandom_range(0, 512) - 256;
            end else if (choice < 85) begin
               left = $urandom;
               right = $urandom;
            end else if (choice < 93) begin
               left = corner_angle();
               right = corner_angle();
            end else begin
               // Standing still: both deltas are zero.
               left = sent_left;
               right = sent_right;
            end
            send_sample(left, right);
            if ($urandom_range(0, 99) == 0) begin
               drain_poses(0);
            end
         end
      end

      drain_poses(SETTLE_CYCLES);
      tracker.close_out();
      $display("Summary: %0d sample words and %0d pose words under %0d gain settings.",
               tracker.samples, tracker.poses, gain_settings);
      $display("Covered: extreme wheel jumps, saturated pose, multi-turn headings, %s",
               "masked register bits and random idling on both channels.");
      if (tracker.mismatches == 0) begin
         $display("differential_drive_odometry_core verification clean");
      end else begin
         $display("%0d mismatches in total", tracker.mismatches);
         $display("differential_drive_odometry_core verification failed");
      end
      $finish;
   end

endmodule
